### design/bcr_pkg.sv
// Shared types, codes and character lookup for the BinHex 4.0 decoder.
package bcr_pkg;

	localparam logic [7:0] RLE_MARKER = 8'h90;
	localparam logic [7:0] CH_COLON   = 8'h3a;

	typedef enum logic [2:0] {
		ST_DATA      = 3'd0,
		ST_FINISHED  = 3'd1,
		ST_BADCHAR   = 3'd2,
		ST_NORUNBYTE = 3'd3,
		ST_DANGLING  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		EV_BYTE  = 2'd0,
		EV_COLON = 2'd1,
		EV_BAD   = 2'd2
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [7:0] data;
	} event_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic [7:0] repeat_count;
		status_t    status;
	} result_t;

	typedef enum logic [1:0] {
		FR_SEEK = 2'd0,
		FR_DATA = 2'd1,
		FR_HALT = 2'd2
	} fr_state_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sextet_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd13) || (c == 8'd10) || (c == 8'd32) || (c == 8'd9);
	endfunction

	// Alphabet position of a character; ok is low outside the alphabet.
	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t    r;
		logic [7:0] v;
		r.ok = 1'b1;
		v    = 8'd0;
		priority if (c >= 8'h21 && c <= 8'h2d) v = c - 8'h21;
		else if (c >= 8'h30 && c <= 8'h36) v = c - 8'h30 + 8'd13;
		else if (c == 8'h38 || c == 8'h39) v = c - 8'h38 + 8'd20;
		else if (c >= 8'h40 && c <= 8'h4e) v = c - 8'h40 + 8'd22;
		else if (c >= 8'h50 && c <= 8'h56) v = c - 8'h50 + 8'd37;
		else if (c >= 8'h58 && c <= 8'h5b) v = c - 8'h58 + 8'd44;
		else if (c >= 8'h60 && c <= 8'h66) v = c - 8'h60 + 8'd48;
		else if (c >= 8'h68 && c <= 8'h6d) v = c - 8'h68 + 8'd55;
		else if (c >= 8'h70 && c <= 8'h72) v = c - 8'h70 + 8'd61;
		else r.ok = 1'b0;
		r.val = v[5:0];
		return r;
	endfunction

endpackage

### design/binhex4_char_rle_decoder.sv
// BinHex 4.0 character decoder with 0x90 run-length expansion.
// Takes one character per cycle while the event queue is not full; a result reaches
// the output ports through the event queue and the result queue, which register it (front and back are combinational).
// Two-entry queues sit between front and back and on the result side.
// Reset (arst_n low) empties both queues and returns to seeking the colon.
module binhex4_char_rle_decoder import bcr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] byte_value,
	output logic [7:0] repeat_count,
	output logic [2:0] status
);
	logic    take;
	logic    fr_valid;
	event_t  fr_ev;
	logic    mid_empty;
	event_t  mid_ev;
	logic    mid_pop;
	logic    res_full;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign take = push && !full;

	bcr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.char_code (char_code),
		.ev_valid  (fr_valid),
		.ev        (fr_ev)
	);

	bcr_fifo #(.WIDTH($bits(event_t))) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fr_valid),
		.wr_data (fr_ev),
		.full    (full),
		.rd_en   (mid_pop),
		.rd_data (mid_ev),
		.empty   (mid_empty)
	);

	bcr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (!mid_empty),
		.ev        (mid_ev),
		.ev_pop    (mid_pop),
		.res_full  (res_full),
		.res_valid (res_valid),
		.res       (res)
	);

	bcr_fifo #(.WIDTH($bits(result_t))) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (out_res),
		.empty   (empty)
	);

	assign byte_value   = out_res.byte_value;
	assign repeat_count = out_res.repeat_count;
	assign status       = out_res.status;
endmodule

### design/bcr_fifo.sv
// Two-entry request queue with registered storage.
module bcr_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

### design/bcr_front.sv
// Character classifier and sextet packer feeding the run-length stage.
module bcr_front import bcr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] char_code,
	output logic       ev_valid,
	output event_t     ev
);
	fr_state_t  state_q, state_d;
	logic [1:0] slot_q, slot_d;
	logic [7:0] part_q, part_d;
	sextet_t    sx;

	assign sx = sextet_of(char_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_SEEK;
			slot_q  <= 2'd0;
			part_q  <= 8'd0;
		end else if (take) begin
			state_q <= state_d;
			slot_q  <= slot_d;
			part_q  <= part_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		slot_d   = slot_q;
		part_d   = part_q;
		ev_valid = 1'b0;
		ev.kind  = EV_BYTE;
		ev.data  = 8'd0;
		unique case (state_q)
			FR_SEEK: begin
				if (char_code == CH_COLON) begin
					state_d = FR_DATA;
				end else if (!is_space(char_code)) begin
					ev_valid = take;
					ev.kind  = EV_BAD;
					state_d  = FR_HALT;
				end
			end
			FR_DATA: begin
				if (char_code == CH_COLON) begin
					ev_valid = take;
					ev.kind  = EV_COLON;
					state_d  = FR_HALT;
				end else if (!is_space(char_code)) begin
					if (!sx.ok) begin
						ev_valid = take;
						ev.kind  = EV_BAD;
						state_d  = FR_HALT;
					end else begin
						unique case (slot_q)
							2'd0: begin
								part_d = {sx.val, 2'b00};
							end
							2'd1: begin
								ev_valid = take;
								ev.data  = part_q | {6'd0, sx.val[5:4]};
								part_d   = {sx.val[3:0], 4'd0};
							end
							2'd2: begin
								ev_valid = take;
								ev.data  = part_q | {4'd0, sx.val[5:2]};
								part_d   = {sx.val[1:0], 6'd0};
							end
							default: begin
								ev_valid = take;
								ev.data  = part_q | {2'd0, sx.val};
								part_d   = 8'd0;
							end
						endcase
						slot_d = slot_q + 2'd1;
					end
				end
			end
			default: begin
				state_d = FR_HALT;
			end
		endcase
	end
endmodule

### design/bcr_back.sv
// Run-length expansion and stream termination.
module bcr_back import bcr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    ev_valid,
	input  event_t  ev,
	output logic    ev_pop,
	input  logic    res_full,
	output logic    res_valid,
	output result_t res
);
	logic       halted_q;
	logic       marker_q;
	logic       have_prev_q;
	logic [7:0] prev_q;
	logic       step;

	assign step   = ev_valid && !res_full;
	assign ev_pop = step;

	always_comb begin
		res_valid        = 1'b0;
		res.byte_value   = 8'd0;
		res.repeat_count = 8'd0;
		res.status       = ST_DATA;
		if (step && !halted_q) begin
			unique case (ev.kind)
				EV_BAD: begin
					res_valid  = 1'b1;
					res.status = ST_BADCHAR;
				end
				EV_COLON: begin
					res_valid  = 1'b1;
					res.status = marker_q ? ST_DANGLING : ST_FINISHED;
				end
				EV_BYTE: begin
					if (marker_q) begin
						if (ev.data == 8'd0) begin
							res_valid        = 1'b1;
							res.byte_value   = RLE_MARKER;
							res.repeat_count = 8'd1;
						end else if (!have_prev_q) begin
							res_valid  = 1'b1;
							res.status = ST_NORUNBYTE;
						end else if (ev.data != 8'd1) begin
							res_valid        = 1'b1;
							res.byte_value   = prev_q;
							res.repeat_count = ev.data - 8'd1;
						end
					end else if (ev.data != RLE_MARKER) begin
						res_valid        = 1'b1;
						res.byte_value   = ev.data;
						res.repeat_count = 8'd1;
					end
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q    <= 1'b0;
			marker_q    <= 1'b0;
			have_prev_q <= 1'b0;
			prev_q      <= 8'd0;
		end else if (step && !halted_q) begin
			unique case (ev.kind)
				EV_BYTE: begin
					if (marker_q) begin
						marker_q <= 1'b0;
						if (ev.data == 8'd0) begin
							prev_q      <= RLE_MARKER;
							have_prev_q <= 1'b1;
						end else if (!have_prev_q) begin
							halted_q <= 1'b1;
						end
					end else if (ev.data == RLE_MARKER) begin
						marker_q <= 1'b1;
					end else begin
						prev_q      <= ev.data;
						have_prev_q <= 1'b1;
					end
				end
				default: begin
					halted_q <= 1'b1;
				end
			endcase
		end
	end
endmodule

### design/bcr_checker.sv
// Port-level checks on the decoder's result queue.
module bcr_checker import bcr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] byte_value,
	input logic [7:0] repeat_count,
	input logic [2:0] status
);
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status <= ST_DANGLING))
		else $error("status code out of range");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_DATA) |-> (repeat_count != 8'd0 && repeat_count != 8'hff))
		else $error("data request with bad repeat count");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_DATA) |-> (byte_value == 8'd0 && repeat_count == 8'd0))
		else $error("status request carries payload");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(byte_value) && $stable(repeat_count)
			&& $stable(status)))
		else $error("stalled request changed");
endmodule

bind binhex4_char_rle_decoder bcr_checker u_bcr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.byte_value   (byte_value),
	.repeat_count (repeat_count),
	.status       (status)
);

### tb/binhex4_char_rle_decoder_tb.sv
// Testbench for the BinHex 4.0 character decoder with run-length expansion.
`timescale 1ns / 1ps

module binhex4_char_rle_decoder_tb;
	import bcr_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int CALM_TAIL  = 150;
	localparam logic [8*64-1:0] GLYPHS =
		"!\"#$%&'()*+,-012345689@ABCDEFGHIJKLMNPQRSTUVXYZ[\140abcdefhijklmpqr";

	function automatic logic [7:0] glyph(input int i);
		return GLYPHS[8*(63-i) +: 8];
	endfunction

	function automatic int glyph_pos(input logic [7:0] c);
		for (int i = 0; i < 64; i++) begin
			if (glyph(i) == c)
				return i;
		end
		return 64;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c inside {8'd9, 8'd10, 8'd13, 8'd32};
	endfunction

	class rle_scoreboard;
		result_t     expected_runs[$];
		fr_state_t   phase;
		logic [1:0]  slot;
		logic [7:0]  part;
		logic [7:0]  prev_b;
		bit          marker;
		bit          have_prev;
		int unsigned mismatches;
		int unsigned results_seen;
		int unsigned data_runs;

		function new();
			phase        = FR_SEEK;
			slot         = 2'd0;
			part         = 8'd0;
			prev_b       = 8'd0;
			marker       = 1'b0;
			have_prev    = 1'b0;
			mismatches   = 0;
			results_seen = 0;
			data_runs    = 0;
		endfunction

		// Decode one accepted character and queue the result (run or status) it yields, if any.
		function void note_char(input logic [7:0] c);
			result_t    r;
			bit         got;
			bit         have_b;
			int         pos;
			logic [7:0] v8;
			logic [7:0] b;
			r.byte_value   = 8'd0;
			r.repeat_count = 8'd0;
			r.status       = ST_DATA;
			got            = 1'b0;
			have_b         = 1'b0;
			b              = 8'd0;
			case (phase)
			FR_SEEK: begin
				if (c == CH_COLON) begin
					phase = FR_DATA;
				end else if (!is_blank(c)) begin
					phase    = FR_HALT;
					r.status = ST_BADCHAR;
					got      = 1'b1;
				end
			end
			FR_DATA: begin
				if (c == CH_COLON) begin
					phase = FR_HALT;
					if (marker)
						r.status = ST_DANGLING;
					else
						r.status = ST_FINISHED;
					got = 1'b1;
				end else if (!is_blank(c)) begin
					pos = glyph_pos(c);
					if (pos == 64) begin
						phase    = FR_HALT;
						r.status = ST_BADCHAR;
						got      = 1'b1;
					end else begin
						v8 = pos[7:0];
						case (slot)
						2'd0: begin
							part = v8 << 2;
						end
						2'd1: begin
							b      = part | (v8 >> 4);
							part   = v8 << 4;
							have_b = 1'b1;
						end
						2'd2: begin
							b      = part | (v8 >> 2);
							part   = v8 << 6;
							have_b = 1'b1;
						end
						default: begin
							b      = part | v8;
							part   = 8'd0;
							have_b = 1'b1;
						end
						endcase
						slot = slot + 2'd1;
					end
				end
			end
			default: begin
			end
			endcase
			if (have_b) begin
				if (marker) begin
					marker = 1'b0;
					if (b == 8'd0) begin
						prev_b         = RLE_MARKER;
						have_prev      = 1'b1;
						r.byte_value   = RLE_MARKER;
						r.repeat_count = 8'd1;
						got            = 1'b1;
					end else if (!have_prev) begin
						phase    = FR_HALT;
						r.status = ST_NORUNBYTE;
						got      = 1'b1;
					end else if (b != 8'd1) begin
						r.byte_value   = prev_b;
						r.repeat_count = b - 8'd1;
						got            = 1'b1;
					end
				end else if (b == RLE_MARKER) begin
					marker = 1'b1;
				end else begin
					prev_b         = b;
					have_prev      = 1'b1;
					r.byte_value   = b;
					r.repeat_count = 8'd1;
					got            = 1'b1;
				end
			end
			if (got)
				expected_runs.push_back(r);
		endfunction

		function void check_result(input logic [7:0] b, input logic [7:0] n,
				input logic [2:0] st);
			result_t want;
			results_seen++;
			if (expected_runs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: byte %02h count %0d status %0d", b, n, st);
			end else begin
				want = expected_runs.pop_front();
				if (want.status == ST_DATA)
					data_runs++;
				if (b !== want.byte_value || n !== want.repeat_count || st !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected byte %02h count %0d status %0d, ",
							"got byte %02h count %0d status %0d"},
							want.byte_value, want.repeat_count, want.status, b, n, st);
				end
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] char_code;
	logic       empty;
	logic       pop;
	logic [7:0] byte_value;
	logic [7:0] repeat_count;
	logic [2:0] status;

	rle_scoreboard sb = new();
	logic [7:0]    byte_plan[$];
	logic [7:0]    text_q[$];
	bit            calm = 1'b0;
	int unsigned   chars_taken = 0;
	int unsigned   idle_cycles = 0;

	binhex4_char_rle_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.char_code    (char_code),
		.empty        (empty),
		.pop          (pop),
		.byte_value   (byte_value),
		.repeat_count (repeat_count),
		.status       (status)
	);

	always #10 clk = ~clk;

	function automatic logic [7:0] random_blank();
		case ($urandom_range(0, 3))
		0: return 8'd9;
		1: return 8'd10;
		2: return 8'd13;
		default: return 8'd32;
		endcase
	endfunction

	function automatic logic [7:0] random_literal();
		logic [7:0] b;
		case ($urandom_range(0, 9))
		0: b = 8'h00;
		1: b = 8'hff;
		default: begin
			do b = 8'($urandom_range(0, 255)); while (b == RLE_MARKER);
		end
		endcase
		return b;
	endfunction

	function automatic logic [7:0] bad_low_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 127));
		while (glyph_pos(c) != 64 || is_blank(c) || c == CH_COLON);
		return c;
	endfunction

	function automatic void queue_text(input logic [7:0] c);
		if ($urandom_range(0, 13) == 0)
			text_q.push_back(random_blank());
		text_q.push_back(c);
	endfunction

	// Pack three bytes into four characters, high bits first; a short last group
	// gets just enough characters to carry its bytes.
	function automatic void encode_plan();
		logic [23:0] w;
		int          rem;
		int          nch;
		for (int i = 0; i < byte_plan.size(); i += 3) begin
			rem = byte_plan.size() - i;
			w[23:16] = byte_plan[i];
			w[15:8]  = (rem > 1) ? byte_plan[i+1] : 8'd0;
			w[7:0]   = (rem > 2) ? byte_plan[i+2] : 8'd0;
			nch = (rem >= 3) ? 4 : rem + 1;
			for (int k = 0; k < nch; k++)
				queue_text(glyph(int'(w[23-6*k -: 6])));
		end
	endfunction

	// Sender holds each request until it is taken.
	task automatic offer_char(input logic [7:0] c);
		push      <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (full);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				sb.note_char(char_code);
				chars_taken++;
			end
			if (pop && !empty)
				sb.check_result(byte_value, repeat_count, status);
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
				$display("binhex4_char_rle_decoder_tb failed");
				$finish;
			end
		end
	end

	initial begin
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			pop <= 1'b1;
		end
	end

	initial begin
		int         ending;
		int         sel;
		string      desc;
		logic [7:0] cnt;
		arst_n    = 1'b0;
		push      = 1'b0;
		char_code = 8'd0;

		ending = $urandom_range(0, 12);
		text_q.push_back(8'd32);
		text_q.push_back(8'd9);
		text_q.push_back(8'd13);
		text_q.push_back(8'd10);
		if (ending == 12) begin
			text_q.push_back(bad_low_char());
			desc = "bad character before the colon";
		end else begin
			text_q.push_back(CH_COLON);
			if (ending == 11) begin
				cnt = 8'($urandom_range(1, 255));
				byte_plan.push_back(RLE_MARKER);
				byte_plan.push_back(cnt);
				encode_plan();
				desc = "run with no earlier byte";
			end else begin
				byte_plan = '{8'h00, 8'hff, RLE_MARKER, 8'h00, 8'h41, RLE_MARKER, 8'h01,
					RLE_MARKER, 8'h02, RLE_MARKER, RLE_MARKER, RLE_MARKER, 8'hff};
				while (byte_plan.size() < 1340) begin
					sel = $urandom_range(0, 19);
					if (sel < 12) begin
						byte_plan.push_back(random_literal());
					end else if (sel < 15) begin
						byte_plan.push_back(RLE_MARKER);
						byte_plan.push_back(8'h00);
					end else begin
						case ($urandom_range(0, 5))
						0: cnt = 8'h01;
						1: cnt = 8'h02;
						2: cnt = RLE_MARKER;
						3: cnt = 8'hff;
						default: cnt = 8'($urandom_range(1, 255));
						endcase
						byte_plan.push_back(RLE_MARKER);
						byte_plan.push_back(cnt);
					end
				end
				if (ending == 6)
					byte_plan.push_back(RLE_MARKER);
				encode_plan();
				if (ending <= 6) begin
					if (ending == 5)
						repeat ($urandom_range(1, 2)) text_q.push_back(glyph($urandom_range(0, 63)));
					text_q.push_back(CH_COLON);
					desc = (ending == 6) ? "colon with a marker pending" : "closing colon";
				end else if (ending <= 8) begin
					text_q.push_back(8'($urandom_range(128, 255)));
					desc = "code above 127";
				end else begin
					text_q.push_back(bad_low_char());
					desc = "character outside the alphabet";
				end
			end
		end
		// halted from here on: noise only
		text_q.push_back(8'($urandom_range(128, 255)));
		repeat (40) text_q.push_back(8'($urandom_range(0, 255)));
		while (text_q.size() < 1950) text_q.push_back(8'($urandom_range(0, 255)));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < text_q.size(); i++) begin
			calm = (i + CALM_TAIL >= text_q.size());
			if (i == text_q.size() / 2) begin
				push <= 1'b0;
				do @(posedge clk); while (sb.expected_runs.size() != 0);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			offer_char(text_q[i]);
		end
		push <= 1'b0;

		while (sb.expected_runs.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("run took %0d characters and checked %0d results, %0d of them byte runs",
			chars_taken, sb.results_seen, sb.data_runs);
		$display("stream ended by %s; %0d mismatches, %0d results still awaited",
			desc, sb.mismatches, sb.expected_runs.size());
		if (sb.mismatches == 0 && sb.expected_runs.size() == 0)
			$display("binhex4_char_rle_decoder_tb passed");
		else
			$display("binhex4_char_rle_decoder_tb failed");
		$finish;
	end

endmodule

### files.f
design/bcr_pkg.sv
design/bcr_fifo.sv
design/bcr_front.sv
design/bcr_back.sv
design/binhex4_char_rle_decoder.sv
design/bcr_checker.sv
tb/binhex4_char_rle_decoder_tb.sv
